/* hw/rtl/cfa_pkg.sv */
// shared constants, codes and controller/datapath interface types for the fit allocator
`default_nettype none

package cfa_pkg;

    // default sizing of the segment table
    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int SIZE_BITS_DEF    = 24;

    // fixed field widths
    localparam int REQ_W       = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int POLICY_W    = 2;
    localparam int OWNER_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int SEG_IDX_W   = 5;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY = 2'd1;

    localparam logic [CFG_DATA_W-1:0] TOTAL_SIZE_RESET = 24'd1048576;

    // placement policies, anything else is first fit
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

    // owner ids run from one to all ones, zero means no owner
    localparam logic [OWNER_W-1:0] OWNER_FIRST = 16'd1;
    localparam logic [OWNER_W-1:0] OWNER_LAST  = 16'hFFFF;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD_REQ,
        OP_SCAN_RD,
        OP_SHIFT_PRIME,
        OP_SHIFT_STEP,
        OP_WRITE_REM,
        OP_WRITE_ALLOC,
        OP_REPORT_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t                op;
        logic [STATUS_W-1:0]   fail_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_pending;
        logic scan_last;
        logic found;
        logic exact;
        logic full;
        logic need_shift;
        logic shift_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/contiguous_fit_allocator.sv */
// top level of the contiguous fit allocator
`default_nettype none

// Contiguous fit allocator. Keeps an ordered table of up to MAX_SEGMENTS
// segments that tile the managed memory, and answers each allocation request
// with one result: allocated (owner id and table position), no_fit or
// table_full. One request is in flight at a time; the block takes a new
// request as soon as the previous one has left the table logic, even while
// its result still waits in the output register. A result that is ready
// while the previous one still waits for out_ready holds the block until
// the output register frees up. The time a request takes is set by the
// single read port of the segment table: the fit scan reads one entry per
// cycle, and splitting the chosen segment moves the entries above it up by
// one, one per cycle, to make room for the remainder. After reset, and
// after every write of total_size, the block rewrites table entry 0
// before it takes a request; configuration writes are always taken at once.

module contiguous_fit_allocator #(
    parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF,
    parameter int SIZE_BITS    = cfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [cfa_pkg::REQ_W-1:0]        request_size,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [cfa_pkg::STATUS_W-1:0]          status,
    output logic [cfa_pkg::OWNER_W-1:0]           owner_id,
    output logic [cfa_pkg::SEG_IDX_W-1:0]         segment_index
);

    cfa_pkg::ctl_cmd_t cmd;
    cfa_pkg::dp_stat_t stat;
    logic              cfg_we;

    // registers live in flops, a write never has to wait
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer: clear, scan, decide, shift, write back
    cfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // segment table, candidate tracking and result register
    cfa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_BITS    (SIZE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .request_size  (request_size),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .status        (status),
        .owner_id      (owner_id),
        .segment_index (segment_index)
    );

endmodule

`default_nettype wire

/* hw/rtl/cfa_ctrl.sv */
// sequencing state machine of the fit allocator
`default_nettype none

module cfa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cfa_pkg::dp_stat_t stat,
    output cfa_pkg::ctl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_SHIFT,
        S_WRITE_REM,
        S_WRITE_ALLOC
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE) && !stat.clear_pending;

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = cfa_pkg::OP_NOP;
        cmd.fail_status = cfa_pkg::ST_NO_FIT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.clear_pending)
                begin
                    cmd.op = cfa_pkg::OP_CLEAR;
                end
                else if (in_valid)
                begin
                    cmd.op     = cfa_pkg::OP_LOAD_REQ;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = cfa_pkg::OP_SCAN_RD;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (!stat.found)
                begin
                    if (stat.out_free)
                    begin
                        cmd.op          = cfa_pkg::OP_REPORT_FAIL;
                        cmd.fail_status = cfa_pkg::ST_NO_FIT;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.exact)
                begin
                    state_next = S_WRITE_ALLOC;
                end
                else if (stat.full)
                begin
                    if (stat.out_free)
                    begin
                        cmd.op          = cfa_pkg::OP_REPORT_FAIL;
                        cmd.fail_status = cfa_pkg::ST_TABLE_FULL;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.need_shift)
                begin
                    cmd.op     = cfa_pkg::OP_SHIFT_PRIME;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_WRITE_REM;
                end
            end
            S_SHIFT:
            begin
                cmd.op = cfa_pkg::OP_SHIFT_STEP;
                if (stat.shift_last)
                begin
                    state_next = S_WRITE_REM;
                end
            end
            S_WRITE_REM:
            begin
                cmd.op     = cfa_pkg::OP_WRITE_REM;
                state_next = S_WRITE_ALLOC;
            end
            S_WRITE_ALLOC:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = cfa_pkg::OP_WRITE_ALLOC;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cfa_datapath.sv */
// segment table memory, fit scan, shift and result registers of the fit allocator
`default_nettype none

module cfa_datapath #(
    parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF,
    parameter int SIZE_BITS    = cfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [cfa_pkg::REQ_W-1:0]        request_size,
    input  wire logic                             out_ready,
    input  wire cfa_pkg::ctl_cmd_t                cmd,
    output cfa_pkg::dp_stat_t                     stat,
    output logic                                  out_valid,
    output logic [cfa_pkg::STATUS_W-1:0]          status,
    output logic [cfa_pkg::OWNER_W-1:0]           owner_id,
    output logic [cfa_pkg::SEG_IDX_W-1:0]         segment_index
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    // segment table
    logic [SIZE_BITS-1:0]        mem_size  [MAX_SEGMENTS];
    logic                        mem_free  [MAX_SEGMENTS];
    logic [cfa_pkg::OWNER_W-1:0] mem_owner [MAX_SEGMENTS];

    // control registers
    logic [cfa_pkg::CFG_DATA_W-1:0] total_size_reg, total_size_next;
    logic [cfa_pkg::POLICY_W-1:0]   fit_policy_reg, fit_policy_next;
    logic                           clear_pending_reg, clear_pending_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [cfa_pkg::OWNER_W-1:0]    next_owner_reg, next_owner_next;
    logic                           found_reg, found_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic                           out_valid_reg, out_valid_next;

    // payload registers
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [IDX_W-1:0]               dst_reg, dst_next;
    logic [SIZE_BITS-1:0]           req_reg, req_next;
    logic [IDX_W-1:0]               pick_reg, pick_next;
    logic [SIZE_BITS-1:0]           key_reg, key_next;
    logic [SIZE_BITS-1:0]           pick_size_reg, pick_size_next;
    logic [IDX_W-1:0]               ev_idx_reg, ev_idx_next;
    logic [SIZE_BITS-1:0]           rd_size_reg;
    logic                           rd_free_reg;
    logic [cfa_pkg::OWNER_W-1:0]    rd_owner_reg;
    logic [cfa_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [cfa_pkg::OWNER_W-1:0]    owner_id_reg, owner_id_next;
    logic [cfa_pkg::SEG_IDX_W-1:0]  seg_idx_reg, seg_idx_next;

    // memory port controls
    logic [IDX_W-1:0]               rd_addr;
    logic                           we;
    logic [IDX_W-1:0]               wr_addr;
    logic [SIZE_BITS-1:0]           wr_size;
    logic                           wr_free;
    logic [cfa_pkg::OWNER_W-1:0]    wr_owner;

    // scan evaluation
    logic                           fits;
    logic [SIZE_BITS-1:0]           leftover;
    logic                           better;
    logic                           out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign fits     = rd_free_reg && (rd_size_reg >= req_reg);
    assign leftover = rd_size_reg - req_reg;

    always_comb
    begin
        priority if (!found_reg)
        begin
            better = 1'b1;
        end
        else if (fit_policy_reg == cfa_pkg::POL_BEST)
        begin
            better = leftover < key_reg;
        end
        else if (fit_policy_reg == cfa_pkg::POL_WORST)
        begin
            better = rd_size_reg > key_reg;
        end
        else
        begin
            better = 1'b0;
        end
    end

    always_comb
    begin
        stat.clear_pending = clear_pending_reg;
        stat.scan_last     = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
        stat.found         = found_reg;
        stat.exact         = pick_size_reg == req_reg;
        stat.full          = count_reg == CNT_W'(MAX_SEGMENTS);
        stat.need_shift    = count_reg != (CNT_W'(pick_reg) + CNT_W'(1));
        stat.shift_last    = (CNT_W'(dst_reg)) == (CNT_W'(pick_reg) + CNT_W'(2));
        stat.out_free      = out_free;
    end

    always_comb
    begin
        total_size_next    = total_size_reg;
        fit_policy_next    = fit_policy_reg;
        clear_pending_next = clear_pending_reg;
        count_next         = count_reg;
        next_owner_next    = next_owner_reg;
        found_next         = found_reg;
        rd_valid_next      = 1'b0;
        out_valid_next     = out_valid_reg && !out_ready;
        idx_next           = idx_reg;
        dst_next           = dst_reg;
        req_next           = req_reg;
        pick_next          = pick_reg;
        key_next           = key_reg;
        pick_size_next     = pick_size_reg;
        ev_idx_next        = ev_idx_reg;
        status_next        = status_reg;
        owner_id_next      = owner_id_reg;
        seg_idx_next       = seg_idx_reg;
        rd_addr            = idx_reg;
        we                 = 1'b0;
        wr_addr            = pick_reg;
        wr_size            = req_reg;
        wr_free            = 1'b0;
        wr_owner           = next_owner_reg;

        unique case (cmd.op)
            cfa_pkg::OP_NOP:
            begin
            end
            cfa_pkg::OP_CLEAR:
            begin
                we                 = 1'b1;
                wr_addr            = '0;
                wr_size            = SIZE_BITS'(total_size_reg);
                wr_free            = 1'b1;
                wr_owner           = '0;
                count_next         = CNT_W'(1);
                next_owner_next    = cfa_pkg::OWNER_FIRST;
                clear_pending_next = 1'b0;
            end
            cfa_pkg::OP_LOAD_REQ:
            begin
                req_next   = SIZE_BITS'(request_size);
                found_next = 1'b0;
                idx_next   = '0;
            end
            cfa_pkg::OP_SCAN_RD:
            begin
                rd_addr       = idx_reg;
                rd_valid_next = 1'b1;
                ev_idx_next   = idx_reg;
                idx_next      = idx_reg + IDX_W'(1);
            end
            cfa_pkg::OP_SHIFT_PRIME:
            begin
                rd_addr  = IDX_W'(count_reg - CNT_W'(1));
                dst_next = IDX_W'(count_reg);
            end
            cfa_pkg::OP_SHIFT_STEP:
            begin
                // move one entry up while fetching the one below it
                we       = 1'b1;
                wr_addr  = dst_reg;
                wr_size  = rd_size_reg;
                wr_free  = rd_free_reg;
                wr_owner = rd_owner_reg;
                rd_addr  = dst_reg - IDX_W'(2);
                dst_next = dst_reg - IDX_W'(1);
            end
            cfa_pkg::OP_WRITE_REM:
            begin
                we         = 1'b1;
                wr_addr    = pick_reg + IDX_W'(1);
                wr_size    = pick_size_reg - req_reg;
                wr_free    = 1'b1;
                wr_owner   = '0;
                count_next = count_reg + CNT_W'(1);
            end
            cfa_pkg::OP_WRITE_ALLOC:
            begin
                we             = 1'b1;
                wr_addr        = pick_reg;
                wr_size        = req_reg;
                wr_free        = 1'b0;
                wr_owner       = next_owner_reg;
                out_valid_next = 1'b1;
                status_next    = cfa_pkg::ST_ALLOCATED;
                owner_id_next  = next_owner_reg;
                seg_idx_next   = cfa_pkg::SEG_IDX_W'(pick_reg);
                if (next_owner_reg == cfa_pkg::OWNER_LAST)
                begin
                    next_owner_next = cfa_pkg::OWNER_FIRST;
                end
                else
                begin
                    next_owner_next = next_owner_reg + cfa_pkg::OWNER_FIRST;
                end
            end
            cfa_pkg::OP_REPORT_FAIL:
            begin
                out_valid_next = 1'b1;
                status_next    = cmd.fail_status;
                owner_id_next  = '0;
                seg_idx_next   = '0;
            end
            default:
            begin
            end
        endcase

        // candidate compare on the entry read in the previous cycle
        if (rd_valid_reg && fits && better)
        begin
            found_next     = 1'b1;
            pick_next      = ev_idx_reg;
            pick_size_next = rd_size_reg;
            key_next       = (fit_policy_reg == cfa_pkg::POL_BEST) ? leftover : rd_size_reg;
        end

        if (cfg_we && (cfg_index == cfa_pkg::CFG_TOTAL_SIZE))
        begin
            total_size_next    = cfg_data;
            clear_pending_next = 1'b1;
        end
        if (cfg_we && (cfg_index == cfa_pkg::CFG_FIT_POLICY))
        begin
            fit_policy_next = cfa_pkg::POLICY_W'(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_size[wr_addr]  <= wr_size;
            mem_free[wr_addr]  <= wr_free;
            mem_owner[wr_addr] <= wr_owner;
        end
        rd_size_reg  <= mem_size[rd_addr];
        rd_free_reg  <= mem_free[rd_addr];
        rd_owner_reg <= mem_owner[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg    <= cfa_pkg::TOTAL_SIZE_RESET;
            fit_policy_reg    <= '0;
            clear_pending_reg <= 1'b1;
            count_reg         <= CNT_W'(1);
            next_owner_reg    <= cfa_pkg::OWNER_FIRST;
            found_reg         <= 1'b0;
            rd_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            total_size_reg    <= total_size_next;
            fit_policy_reg    <= fit_policy_next;
            clear_pending_reg <= clear_pending_next;
            count_reg         <= count_next;
            next_owner_reg    <= next_owner_next;
            found_reg         <= found_next;
            rd_valid_reg      <= rd_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        dst_reg       <= dst_next;
        req_reg       <= req_next;
        pick_reg      <= pick_next;
        key_reg       <= key_next;
        pick_size_reg <= pick_size_next;
        ev_idx_reg    <= ev_idx_next;
        status_reg    <= status_next;
        owner_id_reg  <= owner_id_next;
        seg_idx_reg   <= seg_idx_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign owner_id      = owner_id_reg;
    assign segment_index = seg_idx_reg;

endmodule

`default_nettype wire

/* hw/rtl/cfa_checker.sv */
// port-level checks of the fit allocator and their bind
`default_nettype none

module cfa_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [cfa_pkg::STATUS_W-1:0]     status,
    input wire logic [cfa_pkg::OWNER_W-1:0]      owner_id,
    input wire logic [cfa_pkg::SEG_IDX_W-1:0]    segment_index
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(owner_id)
            && $stable(segment_index))
        else $error("stalled result changed");

    // failures carry no owner and no position
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != cfa_pkg::ST_ALLOCATED) |-> (owner_id == '0)
            && (segment_index == '0))
        else $error("failed request reports owner or position");

    // an allocation never hands out the reserved owner zero
    a_owner_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cfa_pkg::ST_ALLOCATED) |-> owner_id != '0)
        else $error("allocation with owner zero");

    // one request at a time: the request port closes right after a request
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .owner_id      (owner_id),
    .segment_index (segment_index)
);

`default_nettype wire
